>>> design/lced_pkg.sv
// Shared types and constants of the Lab colour edge point detector.
`default_nettype none

package lced_pkg;

    // Fixed field widths
    localparam int POS_W    = 11;
    localparam int ROW_W    = 11;
    localparam int INDEX_W  = 22;
    localparam int NB_COUNT = 4;

    // Frame height limit
    localparam logic [11:0] MAX_HEIGHT = 12'd2048;

    // Colour difference scaling: L weight 100^2, a/b weight 255^2
    localparam logic [13:0] L_SCALE  = 14'd10000;
    localparam logic [15:0] AB_SCALE = 16'd65025;

    // Threshold products after reset (epsilon of 20)
    localparam logic [8:0]  EPSILON_RESET    = 9'd20;
    localparam logic [17:0] EPS_SQ_RESET     = 18'd400;
    localparam logic [34:0] THRESHOLD_RESET  = 35'd26010000;

    // Decision queue depth between front and back
    localparam int QUEUE_DEPTH = 4;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_EPSILON      = 2'd0,
        REG_STRIDE       = 2'd1,
        REG_IMAGE_WIDTH  = 2'd2,
        REG_IMAGE_HEIGHT = 2'd3
    } reg_index_t;

    // Neighbour codes, in test order
    typedef enum logic [1:0] {
        NB_LEFT  = 2'd0,
        NB_RIGHT = 2'd1,
        NB_UP    = 2'd2,
        NB_DOWN  = 2'd3
    } nbr_dir_t;

    // One Lab pixel: L, a, b from MSB down
    typedef logic [23:0] lab_t;

    typedef struct packed {
        logic [7:0] lightness;
        logic [7:0] chroma_a;
        logic [7:0] chroma_b;
        logic       frame_start;
    } pixel_t;

    typedef struct packed {
        logic [POS_W-1:0]   pos_x;
        logic [ROW_W-1:0]   pos_y;
        logic [INDEX_W-1:0] vertex_index;
        logic [1:0]         neighbour;
    } vertex_t;

    typedef struct packed {
        logic [8:0]  epsilon;
        logic [4:0]  stride;
        logic [11:0] image_width;
        logic [11:0] image_height;
    } cfg_t;

    // Work handed from the front to the back for one pixel
    typedef struct packed {
        logic                      clr_before;
        logic                      examine;
        logic                      clr_after;
        lab_t                      centre;
        lab_t [NB_COUNT-1:0]       nbr;
        logic [POS_W-1:0]          pos_x;
        logic [ROW_W-1:0]          pos_y;
        logic [ROW_W-1:0]          row_off;
    } job_t;

    // One restoring remainder step: shift in a bit, subtract divisor if it fits
    function automatic logic [4:0] rem_step(input logic [4:0] r, input logic b,
                                            input logic [4:0] s);
        logic [5:0] t;
        t = {r, b};
        if (t >= {1'b0, s})
        begin
            t = t - {1'b0, s};
        end
        return t[4:0];
    endfunction

    // Squared absolute difference of two 8-bit channels
    function automatic logic [15:0] sq_diff(input logic [7:0] p, input logic [7:0] q);
        logic [7:0] d;
        d = (p > q) ? (p - q) : (q - p);
        return 16'(d) * 16'(d);
    endfunction

endpackage

`default_nettype wire

>>> design/lced_ram.sv
// Generic single-port-write, registered-read RAM.
`default_nettype none

module lced_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and read the old contents
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> design/lced_queue.sv
// Short FIFO between the pixel front end and the decision back end.
`default_nettype none

module lced_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4,
    localparam int PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CW   = $clog2(DEPTH + 1)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  head_valid,
    output logic      [WIDTH-1:0] head_data,
    output logic                  room
);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;

    assign head_valid = (count_reg != '0);
    assign head_data  = entry_reg[rd_ptr_reg];
    // Keep one slot free for the request still in the front's last stage
    assign room       = (count_reg <= CW'(DEPTH - 2));

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (!push && pop)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed request
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

>>> design/lced_front.sv
// Pixel front end: raster counters, line stores, 3x3 window, request building.
`default_nettype none

module lced_front
    import lced_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    localparam int COL_W    = $clog2(MAX_WIDTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             pixel_valid,
    output logic                  pixel_stall,
    input  wire pixel_t           pixel,
    input  wire logic             room,
    output logic                  push,
    output job_t                  job,
    output logic      [COL_W-1:0] col_off
);

    // Compare width: holds column + 1, the register value and MAX_WIDTH
    localparam int CW = (COL_W + 1 > 12) ? COL_W + 1 : 12;
    // Width for the centre column before it is cut to the output field
    localparam int PW = (COL_W > POS_W) ? COL_W : POS_W;

    logic             accept;
    logic [CW-1:0]    w_lim;
    logic [11:0]      h_lim;
    logic [COL_W-1:0] col_eff;
    logic [ROW_W-1:0] row_eff;
    logic [CW-1:0]    col_inc;
    logic [11:0]      row_inc;
    logic [PW-1:0]    cx_wide;
    logic             eof;
    logic             examine;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;

    // Stage F1 registers
    logic             f1_valid_reg;
    lab_t             f1_px_reg;
    logic [COL_W-1:0] f1_addr_reg;
    logic             f1_examine_reg;
    logic             f1_fs_reg;
    logic             f1_eof_reg;
    logic [POS_W-1:0] f1_pos_x_reg;
    logic [ROW_W-1:0] f1_pos_y_reg;
    logic [ROW_W-1:0] f1_row_off_reg;
    logic [COL_W-1:0] f1_col_off_reg;
    logic             f1_fwd_reg;
    logic [47:0]      fwd_data_reg;

    logic [47:0]      ram_rdata;
    lab_t             up_px;
    lab_t             mid_px;

    // Window columns: index 0 is the left column, index 1 the centre column
    lab_t             win_reg [3][2];

    assign pixel_stall = !room;
    assign accept      = pixel_valid && !pixel_stall;

    // Clamp geometry and derive counters for the incoming pixel
    always_comb
    begin
        w_lim   = (CW'(cfg.image_width) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                          : CW'(cfg.image_width);
        h_lim   = (cfg.image_height > MAX_HEIGHT) ? MAX_HEIGHT : cfg.image_height;
        col_eff = pixel.frame_start ? '0 : col_reg;
        row_eff = pixel.frame_start ? '0 : row_reg;
        col_inc = CW'(col_eff) + CW'(1);
        row_inc = 12'(row_eff) + 12'd1;
        cx_wide = PW'(col_eff) - PW'(1);
        eof     = 1'b0;
        col_next = col_inc[COL_W-1:0];
        row_next = row_eff;
        if (col_inc >= w_lim)
        begin
            col_next = '0;
            row_next = row_inc[ROW_W-1:0];
            if (row_inc >= h_lim)
            begin
                row_next = '0;
                eof      = 1'b1;
            end
        end
        examine = (row_eff >= ROW_W'(2)) && (col_eff >= COL_W'(2)) &&
                  (CW'(col_eff) < w_lim) && (12'(row_eff) < h_lim);
    end

    // Hold raster position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg      <= '0;
            row_reg      <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            f1_valid_reg <= accept;
            if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
        end
    end

    // Capture the accepted pixel and its decision context
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_px_reg      <= {pixel.lightness, pixel.chroma_a, pixel.chroma_b};
            f1_addr_reg    <= col_eff;
            f1_examine_reg <= examine;
            f1_fs_reg      <= pixel.frame_start;
            f1_eof_reg     <= eof;
            f1_pos_x_reg   <= cx_wide[POS_W-1:0];
            f1_pos_y_reg   <= row_eff - ROW_W'(1);
            f1_row_off_reg <= row_eff - ROW_W'(2);
            f1_col_off_reg <= col_eff - COL_W'(2);
            // Same column written by the previous pixel this very edge
            f1_fwd_reg     <= f1_valid_reg && (f1_addr_reg == col_eff);
            fwd_data_reg   <= {mid_px, f1_px_reg};
        end
    end

    // Line stores: upper in the high half, middle in the low half
    lced_ram #(
        .WIDTH (48),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk   (clk),
        .we    (f1_valid_reg),
        .waddr (f1_addr_reg),
        .wdata ({mid_px, f1_px_reg}),
        .raddr (col_eff),
        .rdata (ram_rdata)
    );

    // Select stored column, bypassing a write that raced the read
    assign up_px  = f1_fwd_reg ? fwd_data_reg[47:24] : ram_rdata[47:24];
    assign mid_px = f1_fwd_reg ? fwd_data_reg[23:0]  : ram_rdata[23:0];

    // Shift the window by one column
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= '0;
                win_reg[k][1] <= '0;
            end
        end
        else if (f1_valid_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k][0] <= win_reg[k][1];
            end
            win_reg[0][1] <= up_px;
            win_reg[1][1] <= mid_px;
            win_reg[2][1] <= f1_px_reg;
        end
    end

    // Build the request for the back end
    always_comb
    begin
        job.clr_before     = f1_fs_reg;
        job.examine        = f1_examine_reg;
        job.clr_after      = f1_eof_reg;
        job.centre         = win_reg[1][1];
        job.nbr[NB_LEFT]   = win_reg[1][0];
        job.nbr[NB_RIGHT]  = mid_px;
        job.nbr[NB_UP]     = win_reg[0][1];
        job.nbr[NB_DOWN]   = win_reg[2][1];
        job.pos_x          = f1_pos_x_reg;
        job.pos_y          = f1_pos_y_reg;
        job.row_off        = f1_row_off_reg;
    end

    assign col_off = f1_col_off_reg;
    assign push    = f1_valid_reg && (f1_examine_reg || f1_fs_reg || f1_eof_reg);

endmodule

`default_nettype wire

>>> design/lced_back.sv
// Decision back end: stride grid test, CIE76 threshold, vertex numbering, output.
`default_nettype none

module lced_back
    import lced_pkg::*;
#(
    parameter int MAX_WIDTH = 2048,
    localparam int COL_W    = $clog2(MAX_WIDTH)
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire cfg_t             cfg,
    input  wire logic             head_valid,
    input  wire job_t             job,
    input  wire logic [COL_W-1:0] col_off,
    output logic                  pop,
    output logic                  vertex_valid,
    input  wire logic             vertex_stall,
    output vertex_t               vertex
);

    localparam int COL_LO = COL_W / 2;
    localparam int ROW_LO = ROW_W / 2;

    logic             advance;
    logic [4:0]       step_div;

    // Threshold pipeline
    logic [17:0]      eps_sq_reg;
    logic [34:0]      thr_reg;

    // Stage S1
    logic             s1_valid_reg;
    logic             s1_clr_before_reg, s1_examine_reg, s1_clr_after_reg;
    logic [POS_W-1:0] s1_pos_x_reg;
    logic [ROW_W-1:0] s1_pos_y_reg;
    logic [15:0]      s1_dl2_reg [NB_COUNT];
    logic [15:0]      s1_da2_reg [NB_COUNT];
    logic [15:0]      s1_db2_reg [NB_COUNT];
    logic [4:0]       s1_col_rem_reg, s1_row_rem_reg;
    logic [COL_LO-1:0] s1_col_low_reg;
    logic [ROW_LO-1:0] s1_row_low_reg;
    logic [4:0]       col_rem_a, row_rem_a;

    // Stage S2
    logic             s2_valid_reg;
    logic             s2_clr_before_reg, s2_examine_reg, s2_clr_after_reg;
    logic             s2_grid_reg;
    logic [POS_W-1:0] s2_pos_x_reg;
    logic [ROW_W-1:0] s2_pos_y_reg;
    logic [29:0]      s2_l_reg [NB_COUNT];
    logic [32:0]      s2_ab_reg [NB_COUNT];
    logic [4:0]       col_rem_b, row_rem_b;

    // Output stage
    logic [INDEX_W-1:0] vc_reg, vc_next;
    logic [INDEX_W-1:0] vc_start;
    logic [NB_COUNT-1:0] hit;
    logic [33:0]        lhs;
    logic               emit;
    nbr_dir_t           first_dir;
    logic               out_valid_reg;
    vertex_t            out_reg;

    assign advance  = !(out_valid_reg && vertex_stall);
    assign pop      = advance && head_valid;
    assign step_div = (cfg.stride == 5'd0) ? 5'd1 : cfg.stride;

    // Follow epsilon into its scaled square
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_sq_reg <= EPS_SQ_RESET;
            thr_reg    <= THRESHOLD_RESET;
        end
        else
        begin
            eps_sq_reg <= 18'(cfg.epsilon) * 18'(cfg.epsilon);
            thr_reg    <= 35'(eps_sq_reg) * 35'(AB_SCALE);
        end
    end

    // Upper remainder steps of the grid test
    always_comb
    begin
        col_rem_a = '0;
        for (int i = COL_W - 1; i >= COL_LO; i--)
        begin
            col_rem_a = rem_step(col_rem_a, col_off[i], step_div);
        end
        row_rem_a = '0;
        for (int i = ROW_W - 1; i >= ROW_LO; i--)
        begin
            row_rem_a = rem_step(row_rem_a, job.row_off[i], step_div);
        end
    end

    // Lower remainder steps of the grid test
    always_comb
    begin
        col_rem_b = s1_col_rem_reg;
        for (int i = COL_LO - 1; i >= 0; i--)
        begin
            col_rem_b = rem_step(col_rem_b, s1_col_low_reg[i], step_div);
        end
        row_rem_b = s1_row_rem_reg;
        for (int i = ROW_LO - 1; i >= 0; i--)
        begin
            row_rem_b = rem_step(row_rem_b, s1_row_low_reg[i], step_div);
        end
    end

    // Advance stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg <= head_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    // S1: channel differences squared
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_clr_before_reg <= job.clr_before;
            s1_examine_reg    <= job.examine;
            s1_clr_after_reg  <= job.clr_after;
            s1_pos_x_reg      <= job.pos_x;
            s1_pos_y_reg      <= job.pos_y;
            s1_col_rem_reg    <= col_rem_a;
            s1_row_rem_reg    <= row_rem_a;
            s1_col_low_reg    <= col_off[COL_LO-1:0];
            s1_row_low_reg    <= job.row_off[ROW_LO-1:0];
            for (int i = 0; i < NB_COUNT; i++)
            begin
                s1_dl2_reg[i] <= sq_diff(job.centre[23:16], job.nbr[i][23:16]);
                s1_da2_reg[i] <= sq_diff(job.centre[15:8],  job.nbr[i][15:8]);
                s1_db2_reg[i] <= sq_diff(job.centre[7:0],   job.nbr[i][7:0]);
            end
        end
    end

    // S2: scale lightness and chroma terms
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s2_clr_before_reg <= s1_clr_before_reg;
            s2_examine_reg    <= s1_examine_reg;
            s2_clr_after_reg  <= s1_clr_after_reg;
            s2_pos_x_reg      <= s1_pos_x_reg;
            s2_pos_y_reg      <= s1_pos_y_reg;
            s2_grid_reg       <= (col_rem_b == 5'd0) && (row_rem_b == 5'd0);
            for (int i = 0; i < NB_COUNT; i++)
            begin
                s2_l_reg[i]  <= 30'(s1_dl2_reg[i]) * 30'(L_SCALE);
                s2_ab_reg[i] <= (33'(s1_da2_reg[i]) + 33'(s1_db2_reg[i])) *
                                33'(AB_SCALE);
            end
        end
    end

    // Compare each neighbour against the threshold
    always_comb
    begin
        lhs = '0;
        for (int i = 0; i < NB_COUNT; i++)
        begin
            lhs    = 34'(s2_l_reg[i]) + 34'(s2_ab_reg[i]);
            hit[i] = {1'b0, lhs} > thr_reg;
        end
    end

    // Pick the first differing neighbour, number the vertex
    always_comb
    begin
        first_dir = NB_LEFT;
        for (int i = NB_COUNT - 1; i >= 0; i--)
        begin
            if (hit[i])
            begin
                first_dir = nbr_dir_t'(2'(i));
            end
        end
        emit     = s2_valid_reg && s2_examine_reg && s2_grid_reg && (hit != '0);
        vc_start = s2_clr_before_reg ? '0 : vc_reg;
        vc_next  = emit ? vc_start + INDEX_W'(1) : vc_start;
        if (s2_clr_after_reg)
        begin
            vc_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= emit;
            if (s2_valid_reg)
            begin
                vc_reg <= vc_next;
            end
        end
    end

    // Hold the vertex until it is taken
    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_reg.pos_x        <= s2_pos_x_reg;
            out_reg.pos_y        <= s2_pos_y_reg;
            out_reg.vertex_index <= vc_start;
            out_reg.neighbour    <= first_dir;
        end
    end

    assign vertex_valid = out_valid_reg;
    assign vertex       = out_reg;

endmodule

`default_nettype wire

>>> design/lab_color_edge_point_detector_unit.sv
// Top level of the Lab colour edge point detector: configuration and block wiring.
//
// Takes one Lab pixel per clock in raster order and emits a vertex for each
// interior centre on the stride grid whose left, right, upper or lower
// neighbour differs by more than epsilon (CIE76, exact integer test).
// Sustained rate is one pixel per cycle; pixel_stall rises only when the
// four-entry decision queue between the window front end and the arithmetic
// back end is nearly full, i.e. when vertex_stall has held the back end.
// A centre is decided when the pixel one row and one column past it arrives.
// The line stores are one MAX_WIDTH x 48 RAM, read and written once per
// pixel, and need no clearing pass after reset. Registers are written
// through cfg_* (0 epsilon, 1 stride, 2 image_width, 3 image_height) while
// no pixel is in flight, a rule for the user that the block does not
// enforce; frame_start restarts the raster and vertex numbering.
`default_nettype none

module lab_color_edge_point_detector_unit
    import lced_pkg::*;
#(
    parameter int MAX_WIDTH = 2048
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        pixel_valid,
    output logic             pixel_stall,
    input  wire pixel_t      pixel,
    output logic             vertex_valid,
    input  wire logic        vertex_stall,
    output vertex_t          vertex,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [11:0] cfg_data
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ITEM_W = $bits(job_t) + COL_W;

    cfg_t             cfg_reg;
    logic             push;
    job_t             push_job;
    logic [COL_W-1:0] push_col_off;
    logic             room;
    logic             head_valid;
    logic [ITEM_W-1:0] head_data;
    job_t             head_job;
    logic [COL_W-1:0] head_col_off;
    logic             pop;

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.epsilon      <= EPSILON_RESET;
            cfg_reg.stride       <= 5'd1;
            cfg_reg.image_width  <= 12'd640;
            cfg_reg.image_height <= 12'd480;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_EPSILON:      cfg_reg.epsilon      <= cfg_data[8:0];
                REG_STRIDE:       cfg_reg.stride       <= cfg_data[4:0];
                REG_IMAGE_WIDTH:  cfg_reg.image_width  <= cfg_data;
                REG_IMAGE_HEIGHT: cfg_reg.image_height <= cfg_data;
                default:          cfg_reg              <= cfg_reg;
            endcase
        end
    end

    lced_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg_reg),
        .pixel_valid (pixel_valid),
        .pixel_stall (pixel_stall),
        .pixel       (pixel),
        .room        (room),
        .push        (push),
        .job         (push_job),
        .col_off     (push_col_off)
    );

    lced_queue #(
        .WIDTH (ITEM_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  ({push_job, push_col_off}),
        .pop        (pop),
        .head_valid (head_valid),
        .head_data  (head_data),
        .room       (room)
    );

    // Split the queue head back into request and column offset
    assign head_job     = job_t'(head_data[ITEM_W-1:COL_W]);
    assign head_col_off = head_data[COL_W-1:0];

    lced_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .head_valid   (head_valid),
        .job          (head_job),
        .col_off      (head_col_off),
        .pop          (pop),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex)
    );

endmodule

`default_nettype wire

>>> tb/lab_color_edge_point_detector_unit_tb.sv
// Self-checking testbench for the Lab colour edge point detector top level.
`default_nettype none

module lab_color_edge_point_detector_unit_tb;
    import lced_pkg::*;

    localparam int          LINE_MAX      = 2048;
    localparam int          HEIGHT_MAX    = 2048;
    localparam longint      L_WEIGHT      = 10000;
    localparam longint      AB_WEIGHT     = 65025;
    localparam int unsigned RANDOM_ITEMS  = 1250;
    localparam int unsigned SETTLE_CYCLES = 16;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned CYCLE_LIMIT   = 2000000;
    localparam int unsigned CLAMP_ITEMS   = 256;

    logic        clk;
    logic        rst_n;
    logic        pixel_valid;
    logic        pixel_stall;
    pixel_t      pixel;
    logic        vertex_valid;
    logic        vertex_stall;
    vertex_t     vertex;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [11:0] cfg_data;

    // Predicts the vertex stream from accepted pixels and checks the block against it
    class vertex_forecast;
        logic [8:0]         eps;
        logic [4:0]         step;
        logic [11:0]        width;
        logic [11:0]        height;
        lab_t               upper_line [LINE_MAX];
        lab_t               middle_line [LINE_MAX];
        int unsigned        line_fill [LINE_MAX];
        lab_t               win [3][3];
        int unsigned        col;
        int unsigned        row;
        logic [INDEX_W-1:0] vcount;
        vertex_t            pending_vertices [$];
        int unsigned        errors;

        function new();
            eps    = 9'd20;
            step   = 5'd1;
            width  = 12'd640;
            height = 12'd480;
            foreach (upper_line[i])
            begin
                upper_line[i]  = '0;
                middle_line[i] = '0;
                line_fill[i]   = 0;
            end
            foreach (win[i, j])
                win[i][j] = '0;
            col    = 0;
            row    = 0;
            vcount = '0;
            errors = 0;
        endfunction

        function void set_reg(reg_index_t idx, logic [11:0] data);
            case (idx)
                REG_EPSILON:      eps    = data[8:0];
                REG_STRIDE:       step   = data[4:0];
                REG_IMAGE_WIDTH:  width  = data;
                REG_IMAGE_HEIGHT: height = data;
                default:          ;
            endcase
        endfunction

        function longint unsigned gap_sq(logic [7:0] p, logic [7:0] q);
            longint unsigned a;
            longint unsigned b;
            longint unsigned d;
            a = p;
            b = q;
            d = (a > b) ? a - b : b - a;
            return d * d;
        endfunction

        // CIE76 test scaled by 255^2 so that it stays in integers
        function bit exceeds(lab_t c, lab_t n);
            longint unsigned lhs;
            longint unsigned rhs;
            lhs = L_WEIGHT * gap_sq(c[23:16], n[23:16])
                + AB_WEIGHT * (gap_sq(c[15:8], n[15:8]) + gap_sq(c[7:0], n[7:0]));
            rhs = AB_WEIGHT * longint'(eps) * longint'(eps);
            return lhs > rhs;
        endfunction

        // Note one accepted pixel request and queue the vertex it decides, if any
        function void take_pixel(pixel_t p);
            int unsigned w;
            int unsigned h;
            int unsigned s;
            int unsigned cx;
            int unsigned cy;
            int unsigned k;
            lab_t        px;
            lab_t        around [NB_COUNT];
            vertex_t     v;
            bit          found;
            w = (width > LINE_MAX) ? LINE_MAX : width;
            h = (height > HEIGHT_MAX) ? HEIGHT_MAX : height;
            s = (step == 0) ? 1 : step;
            if (p.frame_start)
            begin
                col    = 0;
                row    = 0;
                vcount = '0;
            end
            px = {p.lightness, p.chroma_a, p.chroma_b};

            // Shift the window and rotate the line stores
            for (k = 0; k < 3; k++)
            begin
                win[k][0] = win[k][1];
                win[k][1] = win[k][2];
            end
            win[0][2]        = upper_line[col];
            win[1][2]        = middle_line[col];
            win[2][2]        = px;
            upper_line[col]  = middle_line[col];
            middle_line[col] = px;
            if (line_fill[col] < 2)
                line_fill[col]++;

            // Decide the centre one row and one column back
            if (row >= 2 && col >= 2)
            begin
                cx = col - 1;
                cy = row - 1;
                if (cx + 1 < w && cy + 1 < h && (cx - 1) % s == 0 && (cy - 1) % s == 0)
                begin
                    around[NB_LEFT]  = win[1][0];
                    around[NB_RIGHT] = win[1][2];
                    around[NB_UP]    = win[0][1];
                    around[NB_DOWN]  = win[2][1];
                    found = 1'b0;
                    for (k = 0; k < NB_COUNT && !found; k++)
                    begin
                        if (exceeds(win[1][1], around[k]))
                        begin
                            found          = 1'b1;
                            v.pos_x        = cx[POS_W-1:0];
                            v.pos_y        = cy[ROW_W-1:0];
                            v.vertex_index = vcount;
                            v.neighbour    = nbr_dir_t'(k[1:0]);
                            pending_vertices = {pending_vertices, v};
                            vcount++;
                        end
                    end
                end
            end

            // Advance the raster position
            col++;
            if (col >= w)
            begin
                col = 0;
                row++;
                if (row >= h)
                begin
                    row    = 0;
                    vcount = '0;
                end
            end
        endfunction

        // Compare one accepted vertex with the oldest prediction
        function void match_vertex(vertex_t got);
            vertex_t want;
            if (pending_vertices.size() == 0)
            begin
                $display("%0t: unexpected vertex x=%0d y=%0d index=%0d neighbour=%0d",
                         $time, got.pos_x, got.pos_y, got.vertex_index, got.neighbour);
                errors++;
                return;
            end
            want = pending_vertices.pop_front();
            if (got.pos_x !== want.pos_x)
            begin
                $display("%0t: pos_x expected %0d actual %0d", $time, want.pos_x, got.pos_x);
                errors++;
            end
            if (got.pos_y !== want.pos_y)
            begin
                $display("%0t: pos_y expected %0d actual %0d", $time, want.pos_y, got.pos_y);
                errors++;
            end
            if (got.vertex_index !== want.vertex_index)
            begin
                $display("%0t: vertex_index expected %0d actual %0d",
                         $time, want.vertex_index, got.vertex_index);
                errors++;
            end
            if (got.neighbour !== want.neighbour)
            begin
                $display("%0t: neighbour expected %0d actual %0d",
                         $time, want.neighbour, got.neighbour);
                errors++;
            end
        endfunction

        function int unsigned pending_count();
            return pending_vertices.size();
        endfunction

        // Leading columns whose both line store entries hold written pixels
        function int unsigned settled_width();
            int unsigned n;
            n = 0;
            while (n < LINE_MAX && line_fill[n] >= 2)
                n++;
            return n;
        endfunction
    endclass

    vertex_forecast board;
    lab_t           last_lab;
    int unsigned    hold_count;

    lab_color_edge_point_detector_unit u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .pixel_valid  (pixel_valid),
        .pixel_stall  (pixel_stall),
        .pixel        (pixel),
        .vertex_valid (vertex_valid),
        .vertex_stall (vertex_stall),
        .vertex       (vertex),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever
            #5 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("lab_color_edge_point_detector_unit verification failed");
        $finish;
    end

    // Vertex side: check accepted vertices, stall at random, hold off on demand
    initial
    begin
        int unsigned run_left;
        int unsigned hold_left;
        int unsigned holds_taken;
        int unsigned r;
        vertex_stall <= 1'b0;
        run_left    = 0;
        hold_left   = 0;
        holds_taken = 0;
        forever
        begin
            @(posedge clk);
            if (rst_n && vertex_valid && !vertex_stall)
                board.match_vertex(vertex);
            if (hold_count != holds_taken)
            begin
                holds_taken = hold_count;
                hold_left   = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                vertex_stall <= 1'b1;
                hold_left--;
            end
            else if (run_left > 0)
            begin
                run_left--;
            end
            else
            begin
                r = $urandom_range(99);
                if (r < 55)
                begin
                    vertex_stall <= 1'b0;
                    run_left = $urandom_range(7);
                end
                else if (r < 70)
                begin
                    vertex_stall <= 1'b0;
                    run_left = $urandom_range(60, 20);
                end
                else if (r < 95)
                begin
                    vertex_stall <= 1'b1;
                    run_left = $urandom_range(2);
                end
                else
                begin
                    vertex_stall <= 1'b1;
                    run_left = $urandom_range(20, 8);
                end
            end
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(3, 1);
        return $urandom_range(20, 4);
    endfunction

    // Mostly flat regions with small noise, broken by random colours
    function automatic pixel_t next_pixel(int unsigned contrast);
        pixel_t      p;
        int unsigned r;
        r = $urandom_range(99);
        if (r < contrast)
            last_lab = 24'($urandom);
        else if (r < contrast + (100 - contrast) / 2)
            last_lab = last_lab ^ 24'($urandom & 32'h0007_0707);
        p.lightness   = last_lab[23:16];
        p.chroma_a    = last_lab[15:8];
        p.chroma_b    = last_lab[7:0];
        p.frame_start = 1'b0;
        return p;
    endfunction

    // Epsilon and stride words carry random bits above each register's width
    function automatic logic [11:0] pick_epsilon();
        int unsigned r;
        logic [8:0]  e;
        r = $urandom_range(99);
        if (r < 10)
            e = 9'd0;
        else if (r < 20)
            e = 9'd511;
        else if (r < 60)
            e = 9'($urandom_range(8, 1));
        else if (r < 85)
            e = 9'($urandom_range(80, 9));
        else
            e = 9'($urandom_range(511, 81));
        return {3'($urandom), e};
    endfunction

    function automatic logic [11:0] pick_stride();
        int unsigned r;
        logic [4:0]  s;
        r = $urandom_range(99);
        if (r < 30)
            s = 5'd1;
        else if (r < 45)
            s = 5'($urandom_range(3, 2));
        else if (r < 55)
            s = 5'd0;
        else if (r < 65)
            s = 5'd16;
        else if (r < 72)
            s = 5'd31;
        else
            s = 5'($urandom_range(31, 4));
        return {7'($urandom), s};
    endfunction

    function automatic logic [11:0] pick_width(int unsigned cap);
        int unsigned r;
        int unsigned w;
        r = $urandom_range(99);
        if (r < 8)
            w = $urandom_range(2);
        else if (r < 20)
            w = $urandom_range(24, 13);
        else
            w = $urandom_range(12, 3);
        if (w > cap)
            w = cap;
        return 12'(w);
    endfunction

    function automatic logic [11:0] pick_height();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)
            return 12'($urandom_range(2));
        if (r < 15)
            return 12'($urandom_range(14, 11));
        return 12'($urandom_range(10, 3));
    endfunction

    // Offer one pixel request until accepted, then idle for gap cycles
    task automatic send_pixel(input pixel_t p, input int unsigned gap);
        pixel_valid <= 1'b1;
        pixel       <= p;
        @(posedge clk);
        while (pixel_stall)
            @(posedge clk);
        board.take_pixel(p);
        if (gap > 0)
        begin
            pixel_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Write all four registers back to back
    task automatic load_settings(input logic [11:0] eps_word, input logic [11:0] stride_word,
                                 input logic [11:0] width_word, input logic [11:0] height_word);
        logic [11:0] words [4];
        int unsigned k;
        reg_index_t  idx;
        words[REG_EPSILON]      = eps_word;
        words[REG_STRIDE]       = stride_word;
        words[REG_IMAGE_WIDTH]  = width_word;
        words[REG_IMAGE_HEIGHT] = height_word;
        for (k = REG_EPSILON; k <= REG_IMAGE_HEIGHT; k++)
        begin
            idx = reg_index_t'(k);
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= words[k];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            board.set_reg(idx, words[k]);
        end
        cfg_valid <= 1'b0;
    endtask

    // Drain outstanding vertices, then let the pipeline settle
    task automatic wait_idle();
        while (board.pending_count() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One setting: reprogram while idle, then stream count pixels
    task automatic run_phase(input logic [11:0] eps_word, input logic [11:0] stride_word,
                             input logic [11:0] width_word, input logic [11:0] height_word,
                             input bit fresh, input int unsigned count,
                             input int unsigned contrast, input bit calm, input bit squeeze);
        int unsigned i;
        int unsigned frame_len;
        int unsigned wc;
        int unsigned hc;
        pixel_t      p;
        wait_idle();
        load_settings(eps_word, stride_word, width_word, height_word);
        if (squeeze)
            hold_count++;
        wc = (width_word > LINE_MAX) ? LINE_MAX : width_word;
        hc = (height_word > HEIGHT_MAX) ? HEIGHT_MAX : height_word;
        frame_len = ((wc == 0) ? 1 : wc) * ((hc == 0) ? 1 : hc);
        for (i = 0; i < count; i++)
        begin
            p = next_pixel(contrast);
            p.frame_start = (i == 0 && fresh)
                         || (i > 0 && i % frame_len == 0 && $urandom_range(1) == 1)
                         || ($urandom_range(199) == 0);
            send_pixel(p, calm ? 0 : pick_gap());
        end
        pixel_valid <= 1'b0;
    endtask

    // Channel extremes with a wrap at frame end and a restart mid-frame; stride zero
    task automatic run_directed();
        int unsigned k;
        pixel_t      p;
        wait_idle();
        load_settings(12'hE00, 12'h000, 12'd5, 12'd4);
        for (k = 0; k < 23; k++)
        begin
            p.lightness   = k[1] ? 8'hFF : 8'h00;
            p.chroma_a    = k[2] ? 8'hFF : 8'h00;
            p.chroma_b    = k[3] ? 8'hFF : 8'h00;
            p.frame_start = (k == 0) || (k == 21);
            send_pixel(p, 0);
        end
        pixel_valid <= 1'b0;
    endtask

    // Random settings, with a clamped width, a clamped height and one hold-off
    task automatic run_random();
        int unsigned sent;
        int unsigned count;
        int unsigned cap;
        int unsigned wc;
        int unsigned hc;
        bit          fresh;
        bit          wide_done;
        bit          tall_done;
        bit          squeeze_done;
        logic [11:0] width_word;
        logic [11:0] height_word;
        sent         = 0;
        wide_done    = 1'b0;
        tall_done    = 1'b0;
        squeeze_done = 1'b0;
        while (sent < RANDOM_ITEMS)
        begin
            if (!wide_done && sent >= 300)
            begin
                wide_done = 1'b1;
                run_phase(12'($urandom_range(8, 1)), pick_stride(), 12'hFFF, 12'd3,
                          1'b1, CLAMP_ITEMS, 10, $urandom_range(1) == 1, 1'b0);
                sent += CLAMP_ITEMS;
            end
            else if (!squeeze_done && sent >= 500)
            begin
                squeeze_done = 1'b1;
                run_phase(12'd0, 12'd1, 12'd8, 12'd8, 1'b1, 128, 100, 1'b1, 1'b1);
                sent += 128;
            end
            else if (!tall_done && sent >= 700)
            begin
                tall_done = 1'b1;
                run_phase(12'($urandom_range(8, 1)), pick_stride(), 12'd3, 12'hFFF,
                          1'b1, CLAMP_ITEMS, 10, $urandom_range(1) == 1, 1'b0);
                sent += CLAMP_ITEMS;
            end
            else
            begin
                // A continuing phase keeps the raster position across the new geometry
                fresh = (sent == 0) || ($urandom_range(3) != 0);
                cap   = fresh ? LINE_MAX : board.settled_width();
                width_word  = pick_width(cap);
                height_word = pick_height();
                wc    = (width_word == 0) ? 1 : width_word;
                hc    = (height_word == 0) ? 1 : height_word;
                count = wc * hc;
                if ($urandom_range(1) == 1)
                    count += $urandom_range(count - 1);
                run_phase(pick_epsilon(), pick_stride(), width_word, height_word, fresh,
                          count, $urandom_range(40, 2), $urandom_range(3) == 0, 1'b0);
                sent += count;
            end
        end
    endtask

    // Reset, stimulus, drain and verdict
    initial
    begin
        board = new();
        hold_count   = 0;
        last_lab     = '0;
        rst_n       <= 1'b0;
        pixel_valid <= 1'b0;
        pixel       <= '0;
        cfg_valid   <= 1'b0;
        cfg_index   <= REG_EPSILON;
        cfg_data    <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random();
        wait_idle();
        if (board.errors == 0)
            $display("lab_color_edge_point_detector_unit verification clean");
        else
            $display("lab_color_edge_point_detector_unit verification failed");
        $finish;
    end

endmodule

`default_nettype wire
